@@ rtl/core/uera_pkg.sv @@
// Package for the ultrasonic echo range averager.
// Widths, constants, register indexes, state type and the divider interface structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package uera_pkg;

    localparam int HISTORY_DEPTH = 6;
    localparam int FILL_W        = $clog2(HISTORY_DEPTH + 1);

    localparam int WIDTH_W = 16;   // echo width field
    localparam int BURST_W = 4;    // samples_per_burst, sample counters
    localparam int SUM_W   = 20;   // width accumulator
    localparam int CODE_W  = 8;
    localparam int SLOT_W  = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // Quotient can reach 360 when valid limit is above full scale, so 9 bits
    localparam int QUOT_W = 9;
    localparam int STEP_W = $clog2(QUOT_W);
    localparam int NUM_W  = 28;    // sum * 255
    localparam int DEN_W  = 20;    // 46400 * count

    localparam logic [DEN_W-1:0]   US_PER_FULL_SCALE = DEN_W'(46400);
    localparam logic [NUM_W-1:0]   CODE_FULL_SCALE   = NUM_W'(255);
    localparam logic [QUOT_W-1:0]  CODE_MAX          = QUOT_W'(255);

    localparam logic [BURST_W-1:0]    SPB_RESET   = BURST_W'(10);
    localparam logic [WIDTH_W-1:0]    LIMIT_RESET = WIDTH_W'(30000);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES_PER_BURST = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_VALID_LIMIT_US    = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_DIV,
        ST_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } div_cmd_t;

    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quot;
    } div_stat_t;

    typedef struct packed {
        logic [CODE_W-1:0] distance_code;
        logic [SLOT_W-1:0] slot;
        logic              shifted;
        logic              stored;
    } result_t;

endpackage

`default_nettype wire

@@ rtl/core/ultrasonic_echo_range_averager_top.sv @@
// Top level of the ultrasonic echo range averager.
// Holds config registers and the output register; uses uera_pkg, uera_ctrl, uera_div.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake            Payload
// in        sink       in_valid / in_stall  echo_width_us, echo_started
// out       source     out_valid / out_stall distance_code, slot, shifted, stored
// cfg       sink       cfg_valid / cfg_ready cfg_index, cfg_data
//
// A sample that does not end a burst is absorbed without stalling the input.
// A burst-ending sample with valid echoes goes through the accepting cycle,
//   divider load, 9 divider steps (one quotient bit each on the shared
//   compare/subtract), result capture and hand-off.
// An empty burst skips the divider. rst_n clears counters, sums and history fill;
//   config returns to 10 samples and a 30000 us limit.
// A result waits in the output register while the next samples are taken;
//   a burst end waits to hand off, holding the input, only while that register is full.

module ultrasonic_echo_range_averager_top
    import uera_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // samples in
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [WIDTH_W-1:0]     echo_width_us,
    input  wire logic                   echo_started,
    // results out
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic [CODE_W-1:0]           distance_code,
    output logic [SLOT_W-1:0]           slot,
    output logic                        shifted,
    output logic                        stored,
    // configuration writes
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [BURST_W-1:0] spb_reg,   spb_next;
    logic [WIDTH_W-1:0] limit_reg, limit_next;

    logic      out_valid_reg, out_valid_next;
    result_t   out_reg,       out_next;

    div_cmd_t  div_cmd;
    div_stat_t div_stat;
    logic      res_valid;
    logic      res_take;
    result_t   res;

    // Config always accepted; the user must ensure it is only written while idle, which the block leaves unchecked
    assign cfg_ready = 1'b1;

    always_comb
    begin
        spb_next   = spb_reg;
        limit_next = limit_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_SAMPLES_PER_BURST: spb_next   = cfg_data[BURST_W-1:0];
                CFG_VALID_LIMIT_US:    limit_next = cfg_data[WIDTH_W-1:0];
                default: ;
            endcase
        end
    end

    uera_ctrl u_ctrl (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .echo_width_us     (echo_width_us),
        .echo_started      (echo_started),
        .samples_per_burst (spb_reg),
        .valid_limit_us    (limit_reg),
        .div_cmd           (div_cmd),
        .div_stat          (div_stat),
        .res_valid         (res_valid),
        .res_take          (res_take),
        .res               (res)
    );

    uera_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (div_cmd),
        .stat  (div_stat)
    );

    // Output register: loads when empty or when the current beat leaves
    assign res_take = res_valid && (!out_valid_reg || !out_stall);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (res_take)
        begin
            out_valid_next = 1'b1;
            out_next       = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spb_reg       <= SPB_RESET;
            limit_reg     <= LIMIT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            spb_reg       <= spb_next;
            limit_reg     <= limit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid     = out_valid_reg;
    assign distance_code = out_reg.distance_code;
    assign slot          = out_reg.slot;
    assign shifted       = out_reg.shifted;
    assign stored        = out_reg.stored;

endmodule

`default_nettype wire

@@ rtl/core/uera_div.sv @@
// Restoring divider: one compare/subtract per cycle, one quotient bit per cycle.
// Depends on uera_pkg.
`timescale 1ns / 1ps
`default_nettype none

module uera_div
    import uera_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire div_cmd_t  cmd,
    output div_stat_t      stat
);

    logic              busy_reg,  busy_next;
    logic              done_reg,  done_next;
    logic [STEP_W-1:0] cnt_reg,   cnt_next;
    logic [NUM_W-1:0]  rem_reg,   rem_next;
    logic [NUM_W-1:0]  dsh_reg,   dsh_next;
    logic [QUOT_W-1:0] quot_reg,  quot_next;
    logic              ge;

    assign ge = (rem_reg >= dsh_reg);

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        quot_next = quot_reg;
        if (cmd.start)
        begin
            busy_next = 1'b1;
            cnt_next  = STEP_W'(QUOT_W - 1);
            rem_next  = cmd.num;
            dsh_next  = NUM_W'(cmd.den) << (QUOT_W - 1);
            quot_next = '0;
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                rem_next = rem_reg - dsh_reg;
            end
            quot_next = {quot_reg[QUOT_W-2:0], ge};
            dsh_next  = dsh_reg >> 1;
            cnt_next  = cnt_reg - STEP_W'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        dsh_reg  <= dsh_next;
        quot_reg <= quot_next;
    end

    assign stat.done = done_reg;
    assign stat.quot = quot_reg;

endmodule

`default_nettype wire

@@ rtl/core/uera_ctrl.sv @@
// Sequencer: burst accumulation, history occupancy and divider control.
// Depends on uera_pkg; drives uera_div through div_cmd_t / div_stat_t.
`timescale 1ns / 1ps
`default_nettype none

module uera_ctrl
    import uera_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [WIDTH_W-1:0]  echo_width_us,
    input  wire logic                echo_started,
    input  wire logic [BURST_W-1:0]  samples_per_burst,
    input  wire logic [WIDTH_W-1:0]  valid_limit_us,
    output div_cmd_t                 div_cmd,
    input  wire div_stat_t           div_stat,
    output logic                     res_valid,
    input  wire logic                res_take,
    output result_t                  res
);

    ctrl_state_t       state_reg, state_next;
    logic [SUM_W-1:0]   sum_reg,     sum_next;
    logic [BURST_W-1:0] seen_reg,    seen_next;
    logic [BURST_W-1:0] vseen_reg,   vseen_next;
    logic [FILL_W-1:0]  fill_reg,    fill_next;
    result_t            res_reg,     res_next;

    logic               accept;
    logic               sample_ok;
    logic [SUM_W-1:0]   sum_acc;
    logic [BURST_W-1:0] vseen_acc;
    logic [BURST_W-1:0] burst_len;
    logic               burst_end;
    logic               hist_full;

    assign accept    = in_valid && (state_reg == ST_IDLE);
    assign sample_ok = echo_started && (echo_width_us < valid_limit_us);
    assign sum_acc   = sample_ok ? sum_reg + SUM_W'(echo_width_us) : sum_reg;
    assign vseen_acc = sample_ok ? vseen_reg + BURST_W'(1) : vseen_reg;
    assign burst_len = (samples_per_burst == '0) ? BURST_W'(1) : samples_per_burst;
    assign burst_end = ({1'b0, seen_reg} + 5'd1) >= {1'b0, burst_len};
    assign hist_full = (fill_reg >= FILL_W'(HISTORY_DEPTH));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && burst_end)
                begin
                    state_next = (vseen_acc != '0) ? ST_CALC : ST_DONE;
                end
            end
            ST_CALC: state_next = ST_DIV;
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (res_take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath updates and outputs
    always_comb
    begin
        sum_next    = sum_reg;
        seen_next   = seen_reg;
        vseen_next  = vseen_reg;
        fill_next   = fill_reg;
        res_next    = res_reg;
        div_cmd     = '{start: 1'b0, num: NUM_W'(sum_reg) * CODE_FULL_SCALE,
                        den: US_PER_FULL_SCALE * DEN_W'(vseen_reg)};
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (!burst_end)
                    begin
                        sum_next   = sum_acc;
                        vseen_next = vseen_acc;
                        seen_next  = seen_reg + BURST_W'(1);
                    end
                    else if (vseen_acc != '0)
                    begin
                        // hold totals for the divide
                        sum_next   = sum_acc;
                        vseen_next = vseen_acc;
                    end
                    else
                    begin
                        sum_next   = '0;
                        seen_next  = '0;
                        vseen_next = '0;
                        res_next   = '0;
                    end
                end
            end
            ST_CALC:
            begin
                div_cmd.start = 1'b1;
                sum_next      = '0;
                seen_next     = '0;
                vseen_next    = '0;
                res_next.stored = 1'b1;
                if (hist_full)
                begin
                    res_next.shifted = 1'b1;
                    res_next.slot    = SLOT_W'(HISTORY_DEPTH - 1);
                end
                else
                begin
                    res_next.shifted = 1'b0;
                    res_next.slot    = SLOT_W'(fill_reg);
                    fill_next        = fill_reg + FILL_W'(1);
                end
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    res_next.distance_code = (div_stat.quot > CODE_MAX)
                        ? CODE_W'(CODE_MAX) : div_stat.quot[CODE_W-1:0];
                end
            end
            ST_DONE: ;
            default: ;
        endcase
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);
    assign res       = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            sum_reg   <= '0;
            seen_reg  <= '0;
            vseen_reg <= '0;
            fill_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sum_reg   <= sum_next;
            seen_reg  <= seen_next;
            vseen_reg <= vseen_next;
            fill_reg  <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

endmodule

`default_nettype wire
